/* src/lcj_pkg.sv */
package lcj_pkg;

	localparam int unsigned DEPTH_BITS_DEF = 16;

	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_BSL   = 8'h5C;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_LPAR  = 8'h28;
	localparam logic [7:0] CH_RPAR  = 8'h29;
	localparam logic [7:0] CH_SPACE = 8'h20;

	localparam logic KIND_DATA = 1'b0;
	localparam logic KIND_END  = 1'b1;

	typedef enum logic [3:0] {
		M_NORMAL    = 4'd0,
		M_LINE      = 4'd1,
		M_BLOCK     = 4'd2,
		M_BLK_STAR  = 4'd3,
		M_STR       = 4'd4,
		M_STR_ESC   = 4'd5,
		M_SLASH     = 4'd6,
		M_BSL       = 4'd7,
		M_BSL_CR    = 4'd8
	} lcj_mode_t;

	typedef struct packed {
		logic       kind;
		logic [7:0] in_byte;
	} lcj_in_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       byte_valid;
		logic       run_last;
		logic       stream_end;
	} lcj_out_t;

	// results of one item: count (0..2) and up to two result items
	typedef struct packed {
		logic [1:0] n;
		lcj_out_t   r0;
		lcj_out_t   r1;
	} lcj_emit_t;

	function automatic lcj_out_t mk_res(input logic [7:0] b, input logic last);
		lcj_out_t r;
		r.out_byte   = b;
		r.byte_valid = 1'b1;
		r.run_last   = last;
		r.stream_end = 1'b0;
		return r;
	endfunction

endpackage

/* src/lcj_step.sv */
module lcj_step #(
	parameter int unsigned DEPTH_BITS = lcj_pkg::DEPTH_BITS_DEF
) (
	input  lcj_pkg::lcj_in_t   item,
	input  lcj_pkg::lcj_mode_t mode,
	input  logic [DEPTH_BITS-1:0] depth,
	output lcj_pkg::lcj_mode_t mode_nxt,
	output logic [DEPTH_BITS-1:0] depth_nxt,
	output lcj_pkg::lcj_emit_t emit
);
	import lcj_pkg::*;

	logic [7:0] c;
	assign c = item.in_byte;

	always_comb begin
		mode_nxt  = mode;
		depth_nxt = depth;
		emit      = '0;
		if (item.kind == KIND_END) begin
			emit.n = 2'd1;
			emit.r0.stream_end = 1'b1;
			emit.r0.run_last   = 1'b1;
			unique case (mode)
				M_SLASH: begin
					emit.r0.out_byte   = CH_SLASH;
					emit.r0.byte_valid = 1'b1;
				end
				M_BSL, M_BSL_CR: begin
					emit.r0.out_byte   = CH_BSL;
					emit.r0.byte_valid = 1'b1;
				end
				M_BLK_STAR: begin
					emit.r0.out_byte   = CH_STAR;
					emit.r0.byte_valid = 1'b1;
				end
				default: ;
			endcase
			mode_nxt  = M_NORMAL;
			depth_nxt = '0;
		end else begin
			unique case (mode)
				M_LINE: begin
					emit.n  = 2'd1;
					emit.r0 = mk_res(c, 1'b1);
					if (c == CH_NL) mode_nxt = M_NORMAL;
				end
				M_BLOCK: begin
					if (c == CH_STAR) begin
						mode_nxt = M_BLK_STAR;
					end else begin
						emit.n  = 2'd1;
						emit.r0 = mk_res(c, 1'b1);
					end
				end
				M_BLK_STAR: begin
					emit.n   = 2'd2;
					emit.r0  = mk_res(CH_STAR, 1'b0);
					emit.r1  = mk_res(c, 1'b1);
					mode_nxt = (c == CH_SLASH) ? M_NORMAL : M_BLOCK;
				end
				M_STR: begin
					emit.n  = 2'd1;
					emit.r0 = mk_res(c, 1'b1);
					if (c == CH_BSL) mode_nxt = M_STR_ESC;
					else if (c == CH_QUOTE) mode_nxt = M_NORMAL;
				end
				M_STR_ESC: begin
					emit.n   = 2'd1;
					emit.r0  = mk_res(c, 1'b1);
					mode_nxt = M_STR;
				end
				M_SLASH: begin
					emit.n  = 2'd2;
					emit.r0 = mk_res(CH_SLASH, 1'b0);
					emit.r1 = mk_res(c, 1'b1);
					if (c == CH_SLASH) mode_nxt = M_LINE;
					else if (c == CH_STAR) mode_nxt = M_BLOCK;
					else mode_nxt = M_NORMAL;
				end
				M_BSL, M_BSL_CR: begin
					if (mode == M_BSL && c == CH_CR) begin
						mode_nxt = M_BSL_CR;
					end else if (c == CH_NL) begin
						mode_nxt = M_NORMAL;
					end else begin
						emit.n   = 2'd2;
						emit.r0  = mk_res(CH_BSL, 1'b0);
						emit.r1  = mk_res(c, 1'b1);
						mode_nxt = M_NORMAL;
					end
				end
				default: begin
					mode_nxt = M_NORMAL;
					if (c == CH_SLASH) begin
						mode_nxt = M_SLASH;
					end else if (c == CH_BSL) begin
						mode_nxt = M_BSL;
					end else begin
						emit.n  = 2'd1;
						emit.r0 = mk_res(c, 1'b1);
						if (c == CH_QUOTE) begin
							mode_nxt = M_STR;
						end else if (c == CH_LPAR) begin
							if (depth != '1) depth_nxt = depth + 1'b1;
						end else if (c == CH_RPAR) begin
							if (depth != '0) depth_nxt = depth - 1'b1;
						end else if (c == CH_NL && depth != '0) begin
							emit.r0 = mk_res(CH_SPACE, 1'b1);
						end
					end
				end
			endcase
		end
	end

endmodule

/* src/lcj_outbuf.sv */
module lcj_outbuf (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  lcj_pkg::lcj_emit_t emit,
	output logic [1:0]         room,
	output logic               result_valid,
	input  logic               result_ready,
	output lcj_pkg::lcj_out_t  result
);
	import lcj_pkg::*;

	logic [1:0] cnt_q;
	lcj_out_t   slot_q [2];
	lcj_out_t   slot_d [2];
	logic [1:0] cnt_d;
	logic       pop;
	logic [1:0] base;

	assign pop          = (cnt_q != 2'd0) && result_ready;
	assign base         = cnt_q - {1'b0, pop};
	assign room         = 2'd2 - base;
	assign result_valid = (cnt_q != 2'd0);
	assign result       = slot_q[0];

	always_comb begin
		slot_d[0] = pop ? slot_q[1] : slot_q[0];
		slot_d[1] = slot_q[1];
		cnt_d     = base;
		if (push && emit.n != 2'd0) begin
			if (base == 2'd0) begin
				slot_d[0] = emit.r0;
				slot_d[1] = emit.r1;
			end else begin
				slot_d[1] = emit.r0;
			end
			cnt_d = base + emit.n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else begin
			cnt_q <= cnt_d;
		end
	end

	always_ff @(posedge clk) begin
		slot_q[0] <= slot_d[0];
		slot_q[1] <= slot_d[1];
	end

endmodule

/* src/line_continuation_joiner_core.sv */
// Order: an accepted item is held in the input stage, then its results in the result buffer.
// Throughput: one item per cycle while results are taken and no item yields two results;
// results leave one per cycle, so two-result items slow the input to the result rate.
// Reset: arst_n clears the scan mode to normal, the paren depth to zero and
// empties the input stage and the two-entry result buffer.
module line_continuation_joiner_core #(
	parameter int unsigned DEPTH_BITS = lcj_pkg::DEPTH_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_ready,
	input  lcj_pkg::lcj_in_t  item,
	output logic              result_valid,
	input  logic              result_ready,
	output lcj_pkg::lcj_out_t result
);
	import lcj_pkg::*;

	logic                  valid_s1;
	lcj_in_t               item_s1;
	lcj_mode_t             mode_q;
	logic [DEPTH_BITS-1:0] depth_q;
	lcj_mode_t             mode_nxt;
	logic [DEPTH_BITS-1:0] depth_nxt;
	lcj_emit_t             emit;
	logic [1:0]            room;
	logic                  adv;

	assign adv        = valid_s1 && (emit.n <= room);
	assign item_ready = !valid_s1 || adv;

	lcj_step #(.DEPTH_BITS(DEPTH_BITS)) u_step (
		.item      (item_s1),
		.mode      (mode_q),
		.depth     (depth_q),
		.mode_nxt  (mode_nxt),
		.depth_nxt (depth_nxt),
		.emit      (emit)
	);

	lcj_outbuf u_outbuf (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (adv),
		.emit         (emit),
		.room         (room),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			mode_q   <= M_NORMAL;
			depth_q  <= '0;
		end else begin
			if (item_valid && item_ready) valid_s1 <= 1'b1;
			else if (adv) valid_s1 <= 1'b0;
			if (adv) begin
				mode_q  <= mode_nxt;
				depth_q <= depth_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready) item_s1 <= item;
	end

endmodule
